// ----- src/dft_fundamental_24pt_defines.svh -----
// assertion macros shared by the dft block
`ifndef DFT_FUNDAMENTAL_24PT_DEFINES_SVH
`define DFT_FUNDAMENTAL_24PT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DFT_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dft assertion failed");

// next-cycle implication, disabled while in reset
`define DFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dft assertion failed");

`endif

// ----- src/dft24_pkg.sv -----
// types, constants and coefficient tables of the 24-point dft block
`timescale 1ns / 1ps

package dft24_pkg;

    localparam int WindowLength      = 24;
    localparam int SampleWidth       = 14;
    localparam int SampleBitsDefault = 14;
    localparam int IndexWidth        = 5;
    localparam int CoefWidth         = 15;
    localparam int ProdWidth         = SampleWidth + CoefWidth;
    localparam int AccWidth          = 32;
    localparam int ResultWidth       = 16;
    localparam int QueueDepth        = 4;

    // divide by 60000 as a shift by 5 and a reciprocal multiply by 1/1875
    localparam int PreShift   = 5;
    localparam int MagWidth   = AccWidth - PreShift;
    localparam int RecipWidth = 27;
    localparam int RecipShift = 37;
    localparam int ProdQWidth = RecipShift + ResultWidth;

    localparam logic [AccWidth-1:0]   RoundBias = AccWidth'(30000);
    localparam logic [RecipWidth-1:0] Recip     = RecipWidth'(73300776);

    typedef struct packed {
        logic signed [SampleWidth-1:0] sample;
        logic [IndexWidth-1:0]         index;
        logic                          last;
    } t_qword;

    typedef struct packed {
        logic signed [AccWidth-1:0] cos_sum;
        logic signed [AccWidth-1:0] sin_sum;
    } t_sums;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RE,
        DIV_IM,
        DIV_DONE
    } t_div_state;

    function automatic logic signed [CoefWidth-1:0] cos_coef(input logic [IndexWidth-1:0] idx);
        logic signed [CoefWidth-1:0] c;
        unique case (idx)
            5'd0:    c = 15'sd10000;
            5'd1:    c = 15'sd9659;
            5'd2:    c = 15'sd8660;
            5'd3:    c = 15'sd7071;
            5'd4:    c = 15'sd5000;
            5'd5:    c = 15'sd2588;
            5'd6:    c = 15'sd0;
            5'd7:    c = -15'sd2588;
            5'd8:    c = -15'sd5000;
            5'd9:    c = -15'sd7071;
            5'd10:   c = -15'sd8660;
            5'd11:   c = -15'sd9659;
            5'd12:   c = -15'sd10000;
            5'd13:   c = -15'sd9659;
            5'd14:   c = -15'sd8660;
            5'd15:   c = -15'sd7071;
            5'd16:   c = -15'sd5000;
            5'd17:   c = -15'sd2588;
            5'd18:   c = 15'sd0;
            5'd19:   c = 15'sd2588;
            5'd20:   c = 15'sd5000;
            5'd21:   c = 15'sd7071;
            5'd22:   c = 15'sd8660;
            5'd23:   c = 15'sd9659;
            default: c = 15'sd0;
        endcase
        return c;
    endfunction

    // sine tap is the cosine tap a quarter period (six taps) earlier
    function automatic logic [IndexWidth-1:0] sin_index(input logic [IndexWidth-1:0] idx);
        logic [IndexWidth-1:0] s;
        if (idx >= IndexWidth'(6)) begin
            s = idx - IndexWidth'(6);
        end else begin
            s = idx + IndexWidth'(WindowLength - 6);
        end
        return s;
    endfunction

endpackage

// ----- src/dft_fundamental_24pt.sv -----
// top level of the 24-point single-bin dft at the fundamental
// Samples enter one per cycle whenever full is low and are grouped into windows of 24; each
// window yields one word of real and imaginary parts (cosine and negated sine correlation,
// rounded half away from zero after division by 60000). A short queue decouples sample intake
// from the multiply-accumulate unit, which takes one sample per cycle except while the last
// sample of a window waits for the divider. After the last sample of a window the divider
// forms the real part and then the imaginary part (one reciprocal multiply for each part)
// before the result appears on the output; the next window keeps accumulating meanwhile, but
// its last sample waits until the previous result has been popped.
`timescale 1ns / 1ps

module dft_fundamental_24pt #(
    parameter int SAMPLE_BITS = dft24_pkg::SampleBitsDefault,
    parameter int QUEUE_DEPTH = dft24_pkg::QueueDepth
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic signed [dft24_pkg::SampleWidth-1:0] i_sample,
    output logic                                    empty,
    input  logic                                    pop,
    output logic signed [dft24_pkg::ResultWidth-1:0] o_real_part,
    output logic signed [dft24_pkg::ResultWidth-1:0] o_imag_part
);
    import dft24_pkg::*;

    logic   w_wr;
    t_qword w_in_word;
    logic   w_q_valid;
    t_qword w_q_word;
    logic   w_take;
    logic   w_div_ready;
    logic   w_start;
    t_sums  w_sums;

    dft24_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_full  (full),
        .i_sample(i_sample),
        .o_wr    (w_wr),
        .o_word  (w_in_word)
    );

    dft24_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (w_wr),
        .i_word (w_in_word),
        .o_full (full),
        .o_valid(w_q_valid),
        .o_word (w_q_word),
        .i_take (w_take)
    );

    dft24_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_word     (w_q_word),
        .o_take     (w_take),
        .i_div_ready(w_div_ready),
        .o_start    (w_start),
        .o_sums     (w_sums)
    );

    dft24_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_sums (w_sums),
        .o_ready(w_div_ready),
        .o_empty(empty),
        .i_pop  (pop),
        .o_real (o_real_part),
        .o_imag (o_imag_part)
    );

endmodule

// ----- src/dft24_front.sv -----
// front end: sample sign extension and window position tagging
`timescale 1ns / 1ps
`include "dft_fundamental_24pt_defines.svh"

module dft24_front #(
    parameter int SAMPLE_BITS = dft24_pkg::SampleBitsDefault
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  logic                                   i_full,
    input  logic signed [dft24_pkg::SampleWidth-1:0] i_sample,
    output logic                                   o_wr,
    output dft24_pkg::t_qword                      o_word
);
    import dft24_pkg::*;

    logic [IndexWidth-1:0]         r_index;
    logic [IndexWidth-1:0]         n_index;
    logic                          w_last;
    logic signed [SampleWidth-1:0] w_ext;

    assign o_wr   = i_push && !i_full;
    assign w_last = (r_index >= IndexWidth'(WindowLength - 1));
    assign w_ext  = SampleWidth'(signed'(i_sample[SAMPLE_BITS-1:0]));

    always_comb begin
        n_index = r_index;
        if (o_wr) begin
            n_index = w_last ? '0 : r_index + IndexWidth'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else begin
            r_index <= n_index;
        end
    end

    assign o_word.sample = w_ext;
    assign o_word.index  = r_index;
    assign o_word.last   = w_last;

    `DFT_ASSERT_NEXT(a_window_wrap, i_clk, i_rst_n, o_wr && w_last, r_index == '0)

endmodule

// ----- src/dft24_fifo.sv -----
// short word queue between front end and multiply-accumulate back end
`timescale 1ns / 1ps
`include "dft_fundamental_24pt_defines.svh"

module dft24_fifo #(
    parameter int DEPTH = dft24_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  dft24_pkg::t_qword i_word,
    output logic              o_full,
    output logic              o_valid,
    output dft24_pkg::t_qword o_word,
    input  logic              i_take
);
    import dft24_pkg::*;

    localparam int PtrWidth = $clog2(DEPTH);
    localparam int CntWidth = $clog2(DEPTH + 1);

    t_qword                r_mem [DEPTH];
    logic [PtrWidth-1:0]   r_wr_ptr;
    logic [PtrWidth-1:0]   r_rd_ptr;
    logic [CntWidth-1:0]   r_cnt;
    logic [CntWidth-1:0]   n_cnt;
    logic                  r_out_valid;
    t_qword                r_out;
    logic                  w_load;

    assign o_full  = (r_cnt == CntWidth'(DEPTH));
    assign w_load  = (r_cnt != '0) && (!r_out_valid || i_take);
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !w_load) begin
            n_cnt = r_cnt + CntWidth'(1);
        end else if (!i_wr && w_load) begin
            n_cnt = r_cnt - CntWidth'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrWidth'(1);
            end
            if (w_load) begin
                r_rd_ptr <= (r_rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrWidth'(1);
                r_out_valid <= 1'b1;
            end else if (i_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `DFT_ASSERT(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CntWidth'(DEPTH))

endmodule

// ----- src/dft24_mac.sv -----
// back end: coefficient multiply and window accumulation
`timescale 1ns / 1ps
`include "dft_fundamental_24pt_defines.svh"

module dft24_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dft24_pkg::t_qword i_word,
    output logic              o_take,
    input  logic              i_div_ready,
    output logic              o_start,
    output dft24_pkg::t_sums  o_sums
);
    import dft24_pkg::*;

    logic                        r_p_valid;
    logic                        r_p_last;
    logic signed [ProdWidth-1:0] r_p_cos;
    logic signed [ProdWidth-1:0] r_p_sin;
    logic signed [AccWidth-1:0]  r_cos_acc;
    logic signed [AccWidth-1:0]  r_sin_acc;
    logic signed [ProdWidth-1:0] w_prod_cos;
    logic signed [ProdWidth-1:0] w_prod_sin;
    logic signed [AccWidth-1:0]  w_cos_sum;
    logic signed [AccWidth-1:0]  w_sin_sum;
    logic                        w_advance;

    assign w_prod_cos = ProdWidth'(i_word.sample) * ProdWidth'(cos_coef(i_word.index));
    assign w_prod_sin = ProdWidth'(i_word.sample) *
                        ProdWidth'(cos_coef(sin_index(i_word.index)));

    assign w_advance = r_p_valid && !(r_p_last && !i_div_ready);
    assign o_take    = i_valid && (!r_p_valid || w_advance);

    assign w_cos_sum = r_cos_acc + AccWidth'(r_p_cos);
    assign w_sin_sum = r_sin_acc + AccWidth'(r_p_sin);

    assign o_start        = w_advance && r_p_last;
    assign o_sums.cos_sum = w_cos_sum;
    assign o_sums.sin_sum = w_sin_sum;

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_p_cos  <= w_prod_cos;
            r_p_sin  <= w_prod_sin;
            r_p_last <= i_word.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_cos_acc <= '0;
            r_sin_acc <= '0;
        end else begin
            if (o_take) begin
                r_p_valid <= 1'b1;
            end else if (w_advance) begin
                r_p_valid <= 1'b0;
            end
            if (w_advance) begin
                r_cos_acc <= r_p_last ? '0 : w_cos_sum;
                r_sin_acc <= r_p_last ? '0 : w_sin_sum;
            end
        end
    end

    `DFT_ASSERT_NEXT(a_last_held, i_clk, i_rst_n, r_p_valid && r_p_last && !i_div_ready,
                     r_p_valid && r_p_last)

endmodule

// ----- src/dft24_div.sv -----
// rounding divider by 60000, one reciprocal multiply per part, and result register
`timescale 1ns / 1ps
`include "dft_fundamental_24pt_defines.svh"

module dft24_div (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  dft24_pkg::t_sums                        i_sums,
    output logic                                    o_ready,
    output logic                                    o_empty,
    input  logic                                    i_pop,
    output logic signed [dft24_pkg::ResultWidth-1:0] o_real,
    output logic signed [dft24_pkg::ResultWidth-1:0] o_imag
);
    import dft24_pkg::*;

    t_div_state                    r_state;
    t_div_state                    n_state;
    logic [AccWidth-1:0]           r_mag;
    logic [AccWidth-1:0]           n_mag;
    logic                          r_pos;
    logic                          n_pos;
    logic signed [AccWidth-1:0]    r_sin;
    logic signed [AccWidth-1:0]    n_sin;
    logic signed [ResultWidth-1:0] r_real;
    logic signed [ResultWidth-1:0] n_real;
    logic signed [ResultWidth-1:0] r_imag;
    logic signed [ResultWidth-1:0] n_imag;
    logic [ProdQWidth-1:0]         w_prod;
    logic signed [ResultWidth-1:0] w_q;

    // magnitude plus half the divisor
    function automatic logic [AccWidth-1:0] biased_mag(input logic signed [AccWidth-1:0] s);
        logic [AccWidth-1:0] m;
        m = s[AccWidth-1] ? AccWidth'(-s) : AccWidth'(s);
        return m + RoundBias;
    endfunction

    // floor(m / 60000) as floor((m >> 5) / 1875)
    assign w_prod  = ProdQWidth'(r_mag[AccWidth-1:PreShift]) * ProdQWidth'(Recip);
    assign w_q     = signed'(w_prod[RecipShift +: ResultWidth]);
    assign o_ready = (r_state == DIV_IDLE);
    assign o_empty = (r_state != DIV_DONE);
    assign o_real  = r_real;
    assign o_imag  = r_imag;

    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_pos   = r_pos;
        n_sin   = r_sin;
        n_real  = r_real;
        n_imag  = r_imag;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_start) begin
                    n_mag   = biased_mag(i_sums.cos_sum);
                    n_pos   = (i_sums.cos_sum > 0);
                    n_sin   = i_sums.sin_sum;
                    n_state = DIV_RE;
                end
            end
            DIV_RE: begin
                n_real  = r_pos ? w_q : -w_q;
                n_mag   = biased_mag(r_sin);
                n_pos   = (r_sin > 0);
                n_state = DIV_IM;
            end
            DIV_IM: begin
                n_imag  = r_pos ? -w_q : w_q;
                n_state = DIV_DONE;
            end
            DIV_DONE: begin
                if (i_pop) begin
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_pos  <= n_pos;
        r_sin  <= n_sin;
        r_real <= n_real;
        r_imag <= n_imag;
    end

    `DFT_ASSERT_NEXT(a_re_to_im, i_clk, i_rst_n, r_state == DIV_RE, r_state == DIV_IM)
    `DFT_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_state == DIV_DONE && !i_pop,
                     r_state == DIV_DONE && $stable(r_real) && $stable(r_imag))

endmodule
